>>> rtl/spi_register_access_sequencer_assert.svh
// Assertion macros used by the SPI register access sequencer checker.
`ifndef SPI_REGISTER_ACCESS_SEQUENCER_ASSERT_SVH
`define SPI_REGISTER_ACCESS_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define SRAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sras check failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define SRAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sras check failed");

`endif

>>> rtl/sras_pkg.sv
// Package: types and constants of the SPI register access sequencer.
package sras_pkg;

  localparam logic [7:0] ACK_CMD          = 8'hC1;
  localparam logic [7:0] ACK_ADDR         = 8'hC2;
  localparam logic [7:0] ACK_READY        = 8'h41;
  localparam logic [7:0] ACK_BUSY         = 8'h4E;
  localparam logic [7:0] POLL_BYTE        = 8'h00;
  localparam logic [3:0] ADDR_HIGH_MASK   = 4'hF;
  localparam logic [7:0] POLL_LIMIT_RESET = 8'd30;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_RECEIVE = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CMD   = 3'd1,
    PH_ADDR  = 3'd2,
    PH_SYNC  = 3'd3,
    PH_RDATA = 3'd4,
    PH_WDATA = 3'd5,
    PH_WPOLL = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CMD_NACK   = 3'd1,
    ST_ADDR_NACK  = 3'd2,
    ST_SYNC_TMO   = 3'd3,
    ST_DATA_NACK  = 3'd4,
    ST_WDONE_FAIL = 3'd5
  } status_t;

endpackage

>>> rtl/sras_if.sv
// Interfaces: request and result channels of the sequencer.
interface sras_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic        is_write;
  logic [11:0] address;
  logic [1:0]  length_code;
  logic [63:0] write_data;
  logic [7:0]  rx_byte;

  modport source (output valid, command, is_write, address, length_code, write_data,
                  rx_byte, input ready);
  modport sink   (input valid, command, is_write, address, length_code, write_data,
                  rx_byte, output ready);
endinterface

interface sras_rsp_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       rd_valid;
  logic [2:0] rd_index;
  logic [7:0] rd_byte;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, tx_valid, tx_byte, rd_valid, rd_index, rd_byte, done_res,
                  status, input ready);
  modport sink   (input valid, tx_valid, tx_byte, rd_valid, rd_index, rd_byte, done_res,
                  status, output ready);
endinterface

>>> rtl/spi_register_access_sequencer.sv
// Top level: SPI master sequencer for acknowledged register read and write.
//
// Usage
//   req   : one item per SPI byte event. command = start carries direction,
//           12-bit address, length code and write data; command = receive
//           carries the byte the slave returned during the last sent byte.
//   rsp   : exactly one result item per request item: the next byte to send
//           (tx_valid/tx_byte), a read data byte (rd_valid/rd_index/rd_byte)
//           and, at the end of a transaction, done_res with its status.
//   cfg   : cfg_we/cfg_data write poll_limit (reset 30); zero acts as one.
// Timing
//   An item accepted at an edge has its result in the output register after
//   that edge. Throughput is one item per cycle while results are taken; the
//   next-state logic is a single compare-and-select step per item.
// Reset
//   rst (synchronous) returns the sequencer to idle and empties the output
//   register; poll_limit goes back to 30.
// Back-pressure
//   req.ready is high while the output register is empty or being drained,
//   so a stalled receiver holds its result and stops intake after one item.
module spi_register_access_sequencer
  import sras_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  sras_req_if.sink         req,
  sras_rsp_if.source       rsp
);

  // Sequencer state
  logic [7:0]  poll_limit;
  phase_t      phase,        phase_next;
  logic        write_mode,   write_mode_next;
  logic [7:0]  address_low,  address_low_next;
  logic [1:0]  size_code,    size_code_next;
  logic [3:0]  byte_count,   byte_count_next;
  logic [7:0]  poll_count,   poll_count_next;
  logic [63:0] write_buffer;

  // Result computed for the item being accepted
  logic        tx_valid_next;
  logic [7:0]  tx_byte_next;
  logic        rd_valid_next;
  logic [2:0]  rd_index_next;
  logic [7:0]  rd_byte_next;
  logic        done_next;
  status_t     status_next;

  logic        accept;
  logic [3:0]  total;
  logic [3:0]  byte_count_inc;
  logic [7:0]  poll_lim_eff;
  logic        polls_exhausted;
  logic [7:0]  wr_byte_sel;

  // Output register frees up when empty or taken this cycle
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign total           = 4'd1 << size_code;
  assign byte_count_inc  = byte_count + 4'd1;
  assign poll_lim_eff    = (poll_limit == 8'd0) ? 8'd1 : poll_limit;
  assign polls_exhausted = poll_count >= poll_lim_eff;
  assign wr_byte_sel     = write_buffer[{byte_count_inc[2:0], 3'b000} +: 8];

  // Next state
  always_comb begin
    phase_next       = phase;
    write_mode_next  = write_mode;
    address_low_next = address_low;
    size_code_next   = size_code;
    byte_count_next  = byte_count;
    poll_count_next  = poll_count;
    if (req.command == CMD_START) begin
      write_mode_next  = req.is_write;
      size_code_next   = req.length_code;
      address_low_next = req.address[7:0];
      byte_count_next  = 4'd0;
      poll_count_next  = 8'd0;
      phase_next       = PH_CMD;
    end else begin
      unique case (phase)
        PH_CMD: begin
          phase_next = (req.rx_byte == ACK_CMD) ? PH_ADDR : PH_IDLE;
        end
        PH_ADDR: begin
          if (req.rx_byte != ACK_ADDR) begin
            phase_next = PH_IDLE;
          end else begin
            byte_count_next = 4'd0;
            if (write_mode) begin
              phase_next = PH_WDATA;
            end else begin
              phase_next      = PH_SYNC;
              poll_count_next = 8'd1;
            end
          end
        end
        PH_SYNC: begin
          if (req.rx_byte == ACK_READY) begin
            phase_next      = PH_RDATA;
            byte_count_next = 4'd0;
          end else if (polls_exhausted) begin
            phase_next = PH_IDLE;
          end else begin
            poll_count_next = poll_count + 8'd1;
          end
        end
        PH_RDATA: begin
          byte_count_next = byte_count_inc;
          if (byte_count_inc >= total) phase_next = PH_IDLE;
        end
        PH_WDATA: begin
          if (req.rx_byte != ACK_READY) begin
            phase_next = PH_IDLE;
          end else begin
            byte_count_next = byte_count_inc;
            if (byte_count_inc >= total) begin
              phase_next      = PH_WPOLL;
              poll_count_next = 8'd1;
            end
          end
        end
        PH_WPOLL: begin
          if (req.rx_byte != ACK_BUSY || polls_exhausted) begin
            phase_next = PH_IDLE;
          end else begin
            poll_count_next = poll_count + 8'd1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Result item
  always_comb begin
    tx_valid_next = 1'b0;
    tx_byte_next  = 8'd0;
    rd_valid_next = 1'b0;
    rd_index_next = 3'd0;
    rd_byte_next  = 8'd0;
    done_next     = 1'b0;
    status_next   = ST_OK;
    if (req.command == CMD_START) begin
      // command byte: direction, size code, top address nibble
      tx_valid_next = 1'b1;
      tx_byte_next  = {req.is_write, 1'b0, req.length_code,
                       req.address[11:8] & ADDR_HIGH_MASK};
    end else begin
      unique case (phase)
        PH_CMD: begin
          if (req.rx_byte == ACK_CMD) begin
            tx_valid_next = 1'b1;
            tx_byte_next  = address_low;
          end else begin
            done_next   = 1'b1;
            status_next = ST_CMD_NACK;
          end
        end
        PH_ADDR: begin
          if (req.rx_byte == ACK_ADDR) begin
            tx_valid_next = 1'b1;
            tx_byte_next  = write_mode ? write_buffer[7:0] : POLL_BYTE;
          end else begin
            done_next   = 1'b1;
            status_next = ST_ADDR_NACK;
          end
        end
        PH_SYNC: begin
          if (req.rx_byte != ACK_READY && polls_exhausted) begin
            done_next   = 1'b1;
            status_next = ST_SYNC_TMO;
          end else begin
            tx_valid_next = 1'b1;
            tx_byte_next  = POLL_BYTE;
          end
        end
        PH_RDATA: begin
          rd_valid_next = 1'b1;
          rd_index_next = byte_count[2:0];
          rd_byte_next  = req.rx_byte;
          if (byte_count_inc >= total) begin
            done_next = 1'b1;
          end else begin
            tx_valid_next = 1'b1;
            tx_byte_next  = POLL_BYTE;
          end
        end
        PH_WDATA: begin
          if (req.rx_byte != ACK_READY) begin
            done_next   = 1'b1;
            status_next = ST_DATA_NACK;
          end else begin
            tx_valid_next = 1'b1;
            tx_byte_next  = (byte_count_inc < total) ? wr_byte_sel : POLL_BYTE;
          end
        end
        PH_WPOLL: begin
          if (req.rx_byte != ACK_BUSY) begin
            done_next   = 1'b1;
            status_next = (req.rx_byte == ACK_READY) ? ST_OK : ST_WDONE_FAIL;
          end else if (polls_exhausted) begin
            done_next   = 1'b1;
            status_next = ST_WDONE_FAIL;
          end else begin
            tx_valid_next = 1'b1;
            tx_byte_next  = POLL_BYTE;
          end
        end
        default: begin
          // receive while idle: all-zero result
        end
      endcase
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      poll_limit <= cfg_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      write_mode  <= 1'b0;
      address_low <= 8'd0;
      size_code   <= 2'd0;
      byte_count  <= 4'd0;
      poll_count  <= 8'd0;
    end else if (accept) begin
      phase       <= phase_next;
      write_mode  <= write_mode_next;
      address_low <= address_low_next;
      size_code   <= size_code_next;
      byte_count  <= byte_count_next;
      poll_count  <= poll_count_next;
    end
  end

  // Write data holds from start onwards; read only after a start
  always_ff @(posedge clk) begin
    if (accept && req.command == CMD_START) begin
      write_buffer <= req.write_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.tx_valid <= tx_valid_next;
      rsp.tx_byte  <= tx_byte_next;
      rsp.rd_valid <= rd_valid_next;
      rsp.rd_index <= rd_index_next;
      rsp.rd_byte  <= rd_byte_next;
      rsp.done_res <= done_next;
      rsp.status   <= status_next;
    end
  end

endmodule

>>> rtl/sras_checker.sv
// Checker: port-level properties of the sequencer, bound to the top level.
`include "spi_register_access_sequencer_assert.svh"

module sras_checker
  import sras_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_command,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       rd_valid,
  input logic       done_res,
  input logic [2:0] status
);

  // a start always produces a command byte in the very next result
  `SRAS_ASSERT_NEXT(a_start_sends_cmd, req_valid && req_ready && req_command == CMD_START, rsp_valid && tx_valid && !done_res)

  // status is only meaningful on a closing item
  `SRAS_ASSERT_NOW(a_status_only_done, rsp_valid && !done_res, status == ST_OK)

  // a read byte either closes the transfer or asks for the next one
  `SRAS_ASSERT_NOW(a_rd_tx_or_done, rsp_valid && rd_valid, tx_valid != done_res)

  // no byte to send means a zero byte field
  `SRAS_ASSERT_NOW(a_tx_zero_idle, rsp_valid && !tx_valid, tx_byte == 8'd0)

  // a result held back by the receiver stays offered
  `SRAS_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind spi_register_access_sequencer sras_checker u_sras_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_command (req.command),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .tx_valid    (rsp.tx_valid),
  .tx_byte     (rsp.tx_byte),
  .rd_valid    (rsp.rd_valid),
  .done_res    (rsp.done_res),
  .status      (rsp.status)
);
